### rtl/record_fifo_with_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record FIFO with search
// Shared implication macros used by the checker.
// ----------------------------------------------------------------------------
`ifndef RECORD_FIFO_WITH_SEARCH_CORE_ASSERT_SVH
`define RECORD_FIFO_WITH_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFS_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### rtl/rfs_pkg.sv
// ----------------------------------------------------------------------------
// Record FIFO with search package
// Field widths, command and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int CMD_W  = 2;
    localparam int CODE_W = 32;
    localparam int AGE_W  = 8;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_SEARCH  = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

### rtl/rfs_in_if.sv
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
interface rfs_in_if import rfs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [CODE_W-1:0] item_code;
    logic [AGE_W-1:0]         item_age;

    modport source (output valid, output command, output item_code, output item_age,
                    input ready);
    modport sink (input valid, input command, input item_code, input item_age,
                  output ready);
endinterface

### rtl/rfs_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
interface rfs_out_if import rfs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [CODE_W-1:0] out_code;
    logic [AGE_W-1:0]         out_age;
    logic                     found;
    logic                     is_empty;
    logic [CNT_W-1:0]         entry_count;
    logic [CNT_W-1:0]         even_age_count;
    logic [CNT_W-1:0]         odd_age_count;

    modport source (output valid, output status, output out_code, output out_age,
                    output found, output is_empty, output entry_count,
                    output even_age_count, output odd_age_count, input ready);
    modport sink (input valid, input status, input out_code, input out_age,
                  input found, input is_empty, input entry_count,
                  input even_age_count, input odd_age_count, output ready);
endinterface

### rtl/record_fifo_with_search_core.sv
// ----------------------------------------------------------------------------
// Record FIFO with search
// Bounded FIFO of code/age records with enqueue, dequeue, search and clear.
// ----------------------------------------------------------------------------
// Commands arrive on i_cmd and each one produces exactly one result on o_res.
// Records sit in a ring of QUEUE_DEPTH cells; cell 0 always holds the oldest.
// Enqueue writes the cell at the current count, dequeue reads cell 0 and
// rotates the ring by one place. Enqueue, dequeue and clear deliver their
// result in the cycle after the command transaction.
// A search rotates the ring through all QUEUE_DEPTH places with a single
// comparator on cell 0 and then delivers its result; the full rotation
// leaves the ring in its original order.
// One command is in work at a time. A new command is taken while a result
// is being delivered, so back-to-back enqueues and dequeues run at one per
// cycle when the receiver keeps ready high.
// Reset empties the queue; cell contents are not cleared and are never read
// before they are written. When the receiver stalls, the result is held and
// no further command is accepted until it is taken.
// ----------------------------------------------------------------------------
module record_fifo_with_search_core import rfs_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfs_in_if.sink     i_cmd,
    rfs_out_if.source  o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state                   r_state;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_out_status;
    logic signed [CODE_W-1:0] r_out_code;
    logic [AGE_W-1:0]         r_out_age;
    logic                     r_out_found;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_tally;
    logic [SW-1:0]            r_step;
    logic                     r_found;
    logic signed [CODE_W-1:0] r_key;

    logic [CW-1:0]            n_count;
    logic [CW-1:0]            n_tally;
    logic [STAT_W-1:0]        n_status;
    logic signed [CODE_W-1:0] n_code;
    logic [AGE_W-1:0]         n_age;

    logic                     w_accept;
    logic                     w_load_en;
    logic                     w_deq_shift;
    logic                     w_hit;
    logic signed [CODE_W-1:0] w_code [QUEUE_DEPTH];
    logic [AGE_W-1:0]         w_age  [QUEUE_DEPTH];
    logic [CW-1:0]            w_odd;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_count     = r_count;
        n_tally     = r_tally;
        n_status    = ST_OK;
        n_code      = '0;
        n_age       = '0;
        w_load_en   = 1'b0;
        w_deq_shift = 1'b0;
        if (w_accept) begin
            case (i_cmd.command)
                CMD_ENQUEUE: begin
                    if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_load_en = 1'b1;
                        n_count   = r_count + 1'b1;
                        if (!i_cmd.item_age[0]) begin
                            n_tally = r_tally + 1'b1;
                        end
                    end
                end
                CMD_DEQUEUE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_deq_shift = 1'b1;
                        n_code      = w_code[0];
                        n_age       = w_age[0];
                        n_count     = r_count - 1'b1;
                        if (!w_age[0][0] && (r_tally != '0)) begin
                            n_tally = r_tally - 1'b1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_count = '0;
                    n_tally = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_hit = (w_code[0] == r_key) && (CW'(r_step) < r_count);

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.load  = w_load_en && (r_count == CW'(g));
        assign w_ctl.shift = w_deq_shift || (r_state == S_SEARCH);

        rfs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_load_code (i_cmd.item_code),
            .i_load_age  (i_cmd.item_age),
            .i_nbr_code  (w_code[(g + 1) % QUEUE_DEPTH]),
            .i_nbr_age   (w_age[(g + 1) % QUEUE_DEPTH]),
            .o_code      (w_code[g]),
            .o_age       (w_age[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_tally     <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready
                    && !(w_accept && (i_cmd.command != CMD_SEARCH))) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        r_tally <= n_tally;
                        if (i_cmd.command == CMD_SEARCH) begin
                            r_state <= S_SEARCH;
                            r_key   <= i_cmd.item_code;
                            r_step  <= '0;
                            r_found <= 1'b0;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= n_status;
                            r_out_code   <= n_code;
                            r_out_age    <= n_age;
                            r_out_found  <= 1'b0;
                        end
                    end
                end
                S_SEARCH: begin
                    r_step  <= r_step + 1'b1;
                    r_found <= r_found || w_hit;
                    if (r_step == SW'(QUEUE_DEPTH - 1)) begin
                        r_state      <= S_IDLE;
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_OK;
                        r_out_code   <= '0;
                        r_out_age    <= '0;
                        r_out_found  <= r_found || w_hit;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_odd = r_count - r_tally;

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.out_code       = r_out_code;
    assign o_res.out_age        = r_out_age;
    assign o_res.found          = r_out_found;
    assign o_res.is_empty       = (r_count == '0);
    assign o_res.entry_count    = CNT_W'(r_count);
    assign o_res.even_age_count = CNT_W'(r_tally);
    assign o_res.odd_age_count  = CNT_W'(w_odd);

endmodule

### rtl/rfs_cell.sv
// ----------------------------------------------------------------------------
// Record storage cell
// Holds one record; loads a new one or takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module rfs_cell import rfs_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [CODE_W-1:0] i_load_code,
    input  logic [AGE_W-1:0]         i_load_age,
    input  logic signed [CODE_W-1:0] i_nbr_code,
    input  logic [AGE_W-1:0]         i_nbr_age,
    output logic signed [CODE_W-1:0] o_code,
    output logic [AGE_W-1:0]         o_age
);

    logic signed [CODE_W-1:0] r_code;
    logic [AGE_W-1:0]         r_age;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_code <= i_load_code;
            r_age  <= i_load_age;
        end else if (i_ctl.shift) begin
            r_code <= i_nbr_code;
            r_age  <= i_nbr_age;
        end
    end

    assign o_code = r_code;
    assign o_age  = r_age;

endmodule

### rtl/rfs_checker.sv
// ----------------------------------------------------------------------------
// Record FIFO with search checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "record_fifo_with_search_core_assert.svh"

module rfs_checker import rfs_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [STAT_W-1:0]        i_status,
    input logic signed [CODE_W-1:0] i_out_code,
    input logic [AGE_W-1:0]         i_out_age,
    input logic                     i_found,
    input logic                     i_is_empty,
    input logic [CNT_W-1:0]         i_entry_count,
    input logic [CNT_W-1:0]         i_even_count,
    input logic [CNT_W-1:0]         i_odd_count
);

    // A stalled result transaction stays offered.
    `RFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // Even and odd tallies always add up to the entry count.
    `RFS_ASSERT_NOW(a_tally_sum, i_clk, i_rst_n, i_out_valid,
        CNT_W'(i_even_count + i_odd_count) == i_entry_count)

    // A dequeue from an empty queue returns no record and leaves it empty.
    `RFS_ASSERT_NOW(a_empty_err, i_clk, i_rst_n, i_out_valid && (i_status == ST_EMPTY),
        i_is_empty && (i_out_code == '0) && (i_out_age == '0) && !i_found)

    // A full error never comes with an empty queue or a match.
    `RFS_ASSERT_NOW(a_full_err, i_clk, i_rst_n, i_out_valid && (i_status == ST_FULL),
        !i_is_empty && !i_found && (i_out_code == '0))

endmodule

bind record_fifo_with_search_core rfs_checker u_rfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_out_code    (o_res.out_code),
    .i_out_age     (o_res.out_age),
    .i_found       (o_res.found),
    .i_is_empty    (o_res.is_empty),
    .i_entry_count (o_res.entry_count),
    .i_even_count  (o_res.even_age_count),
    .i_odd_count   (o_res.odd_age_count)
);

### dv/record_fifo_with_search_core_tb.sv
// ----------------------------------------------------------------------------
// Record FIFO with search testbench
// Drives enqueue, dequeue, search and clear transactions into the core, keeps
// a queue-based prediction of its contents, and checks every field of every
// result transaction in order, under several mixes of source and sink stalls.
// ----------------------------------------------------------------------------
module record_fifo_with_search_core_tb;
    import rfs_pkg::*;

    localparam int QUEUE_DEPTH = 16;

    typedef struct {
        logic signed [CODE_W-1:0] code;
        logic [AGE_W-1:0]         age;
    } t_record;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [CODE_W-1:0] out_code;
        logic [AGE_W-1:0]         out_age;
        logic                     found;
        logic                     is_empty;
        logic [CNT_W-1:0]         entry_count;
        logic [CNT_W-1:0]         even_age_count;
        logic [CNT_W-1:0]         odd_age_count;
    } t_fifo_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfs_in_if  cmd_if ();
    rfs_out_if res_if ();

    record_fifo_with_search_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    t_record      held_records[$];
    int           even_held;
    t_fifo_result awaited_results[$];

    int src_idle_pct;
    int sink_idle_pct;
    int failures;
    int n_enqueue, n_dequeue, n_search, n_clear;
    int n_full, n_empty, n_hits, n_results;

    always #2 i_clk = ~i_clk;

    function automatic t_fifo_result next_fifo_result(input t_cmd cmd,
                                                     input logic signed [CODE_W-1:0] code,
                                                     input logic [AGE_W-1:0] age);
        t_fifo_result r;
        t_record      rec;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ENQUEUE: begin
                n_enqueue++;
                if (held_records.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    rec.code = code;
                    rec.age  = age;
                    held_records.push_back(rec);
                    if (!age[0]) even_held++;
                end
            end
            CMD_DEQUEUE: begin
                n_dequeue++;
                if (held_records.size() == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    rec = held_records.pop_front();
                    r.out_code = rec.code;
                    r.out_age  = rec.age;
                    if (!rec.age[0]) even_held--;
                end
            end
            CMD_SEARCH: begin
                n_search++;
                foreach (held_records[i]) begin
                    if (held_records[i].code == code) r.found = 1'b1;
                end
                if (r.found) n_hits++;
            end
            CMD_CLEAR: begin
                n_clear++;
                held_records.delete();
                even_held = 0;
            end
        endcase
        r.is_empty       = (held_records.size() == 0);
        r.entry_count    = CNT_W'(held_records.size());
        r.even_age_count = CNT_W'(even_held);
        r.odd_age_count  = CNT_W'(held_records.size() - even_held);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CODE_W-1:0] exp_v,
                               input logic [CODE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    task automatic check_result();
        t_fifo_result e;
        if (awaited_results.size() == 0) begin
            $error("result transaction with no command pending");
            failures++;
            return;
        end
        e = awaited_results.pop_front();
        n_results++;
        check_field("status", e.status, res_if.status);
        check_field("out_code", e.out_code, res_if.out_code);
        check_field("out_age", e.out_age, res_if.out_age);
        check_field("found", e.found, res_if.found);
        check_field("is_empty", e.is_empty, res_if.is_empty);
        check_field("entry_count", e.entry_count, res_if.entry_count);
        check_field("even_age_count", e.even_age_count, res_if.even_age_count);
        check_field("odd_age_count", e.odd_age_count, res_if.odd_age_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_cmd(input t_cmd cmd, input logic signed [CODE_W-1:0] code,
                            input logic [AGE_W-1:0] age);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= cmd;
        cmd_if.item_code <= code;
        cmd_if.item_age  <= age;
        do @(posedge i_clk); while (!cmd_if.ready);
        awaited_results.push_back(next_fifo_result(cmd, code, age));
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    task automatic test_empty_queue();
        send_cmd(CMD_DEQUEUE, 32'sd0, 8'd0);
        send_cmd(CMD_SEARCH, 32'sd0, 8'd0);
        send_cmd(CMD_CLEAR, 32'sd0, 8'd0);
    endtask

    task automatic test_fill_and_overflow();
        send_cmd(CMD_ENQUEUE, 32'sh8000_0000, 8'd0);
        send_cmd(CMD_ENQUEUE, 32'sh7FFF_FFFF, 8'd255);
        send_cmd(CMD_ENQUEUE, -32'sd1, 8'd1);
        send_cmd(CMD_ENQUEUE, 32'sd0, 8'd254);
        while (held_records.size() < QUEUE_DEPTH)
            send_cmd(CMD_ENQUEUE, $urandom, $urandom_range(255));
        send_cmd(CMD_ENQUEUE, 32'sh5555_5555, 8'hAA);
        send_cmd(CMD_ENQUEUE, 32'sh5555_5555, 8'h55);
    endtask

    task automatic test_search_and_drain();
        send_cmd(CMD_SEARCH, 32'sh8000_0000, 8'd0);
        send_cmd(CMD_SEARCH, held_records[$].code, 8'd0);
        send_cmd(CMD_SEARCH, 32'sh5555_5555, 8'd0);
        send_cmd(CMD_DEQUEUE, 32'sd0, 8'd0);
        send_cmd(CMD_SEARCH, 32'sh8000_0000, 8'd0);
        send_cmd(CMD_DEQUEUE, 32'sd0, 8'd0);
        send_cmd(CMD_CLEAR, 32'sd0, 8'd0);
        send_cmd(CMD_SEARCH, 32'sh7FFF_FFFF, 8'd0);
        send_cmd(CMD_DEQUEUE, 32'sd0, 8'd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                       burst_left;
        int                       enq_pct;
        int                       deq_pct;
        int                       pick;
        t_cmd                     cmd;
        logic signed [CODE_W-1:0] code;
        logic signed [CODE_W-1:0] last_out;
        burst_left = 0;
        enq_pct    = 50;
        deq_pct    = 30;
        last_out   = 32'sd0;
        for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 6);
                case ($urandom_range(2))
                    0: begin enq_pct = 65; deq_pct = 15; end
                    1: begin enq_pct = 20; deq_pct = 60; end
                    default: begin enq_pct = 40; deq_pct = 35; end
                endcase
            end
            burst_left--;
            pick = $urandom_range(99);
            if (pick < enq_pct) cmd = CMD_ENQUEUE;
            else if (pick < enq_pct + deq_pct) cmd = CMD_DEQUEUE;
            else if (pick < 98) cmd = CMD_SEARCH;
            else cmd = CMD_CLEAR;
            pick = $urandom_range(9);
            if (cmd == CMD_SEARCH && pick < 5 && held_records.size() != 0)
                code = held_records[$urandom_range(held_records.size() - 1)].code;
            else if (cmd == CMD_SEARCH && pick == 5)
                code = last_out;
            else if (pick < 8)
                code = $urandom;
            else if (pick == 8)
                code = $signed(CODE_W'($urandom_range(7))) - 32'sd4;
            else
                code = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            if (cmd == CMD_DEQUEUE && held_records.size() != 0)
                last_out = held_records[0].code;
            send_cmd(cmd, code, $urandom_range(255));
            if ($urandom_range(99) == 0) wait_drained();
        end
    endtask

    initial begin
        cmd_if.valid     <= 1'b0;
        cmd_if.command   <= CMD_ENQUEUE;
        cmd_if.item_code <= '0;
        cmd_if.item_age  <= '0;
        i_rst_n          <= 1'b0;
        even_held = 0;
        failures  = 0;
        set_idling(13, 57);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        test_search_and_drain();
        test_random_traffic(340);
        wait_drained();
        set_idling(57, 13);
        test_random_traffic(340);
        wait_drained();
        set_idling(0, 0);
        test_random_traffic(340);
        wait_drained();
        repeat (QUEUE_DEPTH + 4) @(posedge i_clk);

        $display("Checked %0d results: %0d enqueues (%0d full), %0d dequeues (%0d empty),",
                 n_results, n_enqueue, n_full, n_dequeue, n_empty);
        $display("%0d searches (%0d hits) and %0d clears, with varied stalls on both sides.",
                 n_search, n_hits, n_clear);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
